### src/kts_pkg.sv
// shared types, constants and table functions for the keyboard tone synthesizer
`timescale 1ns / 1ps

package kts_pkg;

    localparam int KEY_W    = 8;
    localparam int SAMPLE_W = 16;
    localparam int LEN_W    = 16;
    localparam int AMP_W    = 15;
    localparam int OCT_W    = 4;
    localparam int NOTE_W   = 4;
    localparam int MAG_W    = 31;
    localparam int Q30_SHIFT = 30;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_TONE_LENGTH = 1'b0;
    localparam t_cfg_idx REG_AMPLITUDE   = 1'b1;

    localparam logic ACTION_KEY  = 1'b0;
    localparam logic ACTION_TICK = 1'b1;

    localparam logic [KEY_W-1:0] KEY_QUIT_UPPER = 8'h51;
    localparam logic [KEY_W-1:0] KEY_QUIT_LOWER = 8'h71;
    localparam logic [KEY_W-1:0] KEY_OCT_DOWN   = 8'h2D;
    localparam logic [KEY_W-1:0] KEY_OCT_UP     = 8'h2B;

    localparam int NOTE_COUNT   = 12;
    localparam int OCTAVE_COUNT = 9;

    // a z s x d f c g v h b j
    localparam logic [KEY_W-1:0] NOTE_KEYS [NOTE_COUNT] = '{
        8'h61, 8'h7A, 8'h73, 8'h78, 8'h64, 8'h66,
        8'h63, 8'h67, 8'h76, 8'h68, 8'h62, 8'h6A
    };

    // octave 4 frequencies in millihertz
    localparam logic [19:0] NOTE_MHZ [NOTE_COUNT] = '{
        20'd261626, 20'd277183, 20'd293665, 20'd311127, 20'd329628, 20'd349228,
        20'd369994, 20'd391995, 20'd415305, 20'd440000, 20'd466164, 20'd493883
    };

    localparam logic [OCT_W-1:0] OCT_MIN   = 4'd0;
    localparam logic [OCT_W-1:0] OCT_MAX   = 4'd8;
    localparam logic [OCT_W-1:0] OCT_RESET = 4'd4;

    localparam logic [LEN_W-1:0] LEN_RESET = 16'd22050;
    localparam logic [AMP_W-1:0] AMP_RESET = 15'd30000;

    localparam int SAMPLE_RATE_HZ = 44100;
    localparam logic [95:0] STEP_DIV = 96'(1000 * SAMPLE_RATE_HZ);

    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;

    localparam logic [63:0] TAYLOR_DIV [8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    typedef struct packed {
        logic              hit;
        logic [NOTE_W-1:0] note;
    } t_note_hit;

    function automatic t_note_hit note_of_key(input logic [KEY_W-1:0] key);
        t_note_hit res;
        res = '0;
        for (int i = 0; i < NOTE_COUNT; i++) begin
            if (key == NOTE_KEYS[i]) begin
                res.hit  = 1'b1;
                res.note = NOTE_W'(i);
            end
        end
        return res;
    endfunction

    // sine of a q2.30 angle by taylor series through x^17, clamped to [0, 1.0]
    function automatic logic [MAG_W-1:0] sine_q30(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [65:0] sum;
        x2   = (x * x) >> Q30_SHIFT;
        term = x;
        sum  = $signed({2'b00, x});
        for (int i = 0; i < 8; i++) begin
            term = ((term * x2) >> Q30_SHIFT) / TAYLOR_DIV[i];
            if (i[0] == 1'b0) begin
                sum = sum - $signed({2'b00, term});
            end else begin
                sum = sum + $signed({2'b00, term});
            end
        end
        if (sum < 0) begin
            sum = '0;
        end else if (sum > $signed({2'b00, Q30_ONE})) begin
            sum = $signed({2'b00, Q30_ONE});
        end
        return sum[MAG_W-1:0];
    endfunction

    // rounded phase step before masking to the accumulator width
    function automatic logic [95:0] phase_step_q(input int note, input int oct,
                                                 input int pbits);
        logic [95:0] num;
        logic [95:0] q;
        num = 96'(NOTE_MHZ[note]) << (pbits + oct - 3);
        q   = num / STEP_DIV;
        return (q + 96'd1) >> 1;
    endfunction

endpackage

### src/kts_if.sv
// handshake channels for key/tick beats and sample beats
`timescale 1ns / 1ps

interface kts_in_if;
    logic                      valid;
    logic                      ready;
    logic                      action;
    logic [kts_pkg::KEY_W-1:0] key_code;

    modport source (output valid, output action, output key_code, input ready);
    modport sink   (input valid, input action, input key_code, output ready);
endinterface

interface kts_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [kts_pkg::SAMPLE_W-1:0] sample;
    logic                                tone_end;

    modport source (output valid, output sample, output tone_end, input ready);
    modport sink   (input valid, input sample, input tone_end, output ready);
endinterface

### src/kts_sine_rom.sv
// quarter-wave sine table with registered read
`timescale 1ns / 1ps

module kts_sine_rom #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic [$clog2(SINE_TABLE_DEPTH+1)-1:0]  i_addr,
    output logic [kts_pkg::MAG_W-1:0]              o_data
);

    localparam int ENTRIES = SINE_TABLE_DEPTH + 1;

    logic [kts_pkg::MAG_W-1:0] w_table [ENTRIES];
    logic [kts_pkg::MAG_W-1:0] r_data;

    for (genvar k = 0; k < ENTRIES; k++) begin : g_entry
        localparam logic [63:0] X = (kts_pkg::PI_HALF_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
        assign w_table[k] = kts_pkg::sine_q30(X);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= w_table[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

### src/keyboard_tone_synthesizer.sv
// keyboard tone synthesizer top level: key decode, phase accumulator, sine sample path
//
// usage
//   i_in carries one beat per key event (action 0, key_code) or sample tick (action 1).
//   o_out carries one signed sample beat for each tick that falls inside a tone;
//   tone_end marks the last sample of the tone. other beats give no result.
//   i_cfg_we / i_cfg_index / i_cfg_data write tone_length (0) and amplitude (1)
//   while the block is idle.
// pipeline and throughput
//   a tick's sample is registered at the quarter-wave table read, then again
//   after the amplitude multiply, and then appears on o_out.
//   one beat per cycle is taken while o_out keeps pace.
// reset
//   synchronous active-low reset clears the pipeline, sets octave 4, no tone,
//   tone_length 22050 and amplitude 30000. the sine table is constant.
// stall
//   when o_out is held off, the output register keeps its sample; i_in still
//   takes a beat while the middle stage is empty, then ready drops until
//   o_out drains.
`timescale 1ns / 1ps

module keyboard_tone_synthesizer #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int PHASE_BITS       = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    kts_in_if.sink                              i_in,
    kts_out_if.source                           o_out,
    input  logic                                i_cfg_we,
    input  logic [kts_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [kts_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int POS_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int IDX_W  = POS_W + 2;
    localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PROD_W = kts_pkg::AMP_W + kts_pkg::MAG_W;

    // phase step table, one entry per note and octave
    logic [PHASE_BITS-1:0] w_step [kts_pkg::NOTE_COUNT][kts_pkg::OCTAVE_COUNT];

    for (genvar n = 0; n < kts_pkg::NOTE_COUNT; n++) begin : g_note
        for (genvar o = 0; o < kts_pkg::OCTAVE_COUNT; o++) begin : g_oct
            localparam logic [95:0] Q = kts_pkg::phase_step_q(n, o, PHASE_BITS);
            assign w_step[n][o] = Q[PHASE_BITS-1:0];
        end
    end

    logic [PHASE_BITS-1:0]         r_phase, n_phase;
    logic [PHASE_BITS-1:0]         r_step, n_step;
    logic [kts_pkg::OCT_W-1:0]     r_octave, n_octave;
    logic [kts_pkg::LEN_W-1:0]     r_left, n_left;
    logic                          r_halted, n_halted;
    logic [kts_pkg::LEN_W-1:0]     r_tone_length;
    logic [kts_pkg::AMP_W-1:0]     r_amplitude;

    logic                          r_s1_valid, r_s1_neg, r_s1_end;
    logic                          r_out_valid, r_out_end;
    logic signed [kts_pkg::SAMPLE_W-1:0] r_out_sample;

    logic                          w_out_free, w_s1_adv, w_accept, w_tick;
    kts_pkg::t_note_hit            w_hit;
    logic [IDX_W-1:0]              w_idx;
    logic [1:0]                    w_quad;
    logic [ADDR_W-1:0]             w_pos, w_addr;
    logic [kts_pkg::MAG_W-1:0]     w_mag;
    logic [PROD_W-1:0]             w_prod;
    logic [kts_pkg::SAMPLE_W-1:0]  w_val;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_s1_adv   = !r_s1_valid || w_out_free;
    assign i_in.ready = w_s1_adv;
    assign w_accept   = i_in.valid && w_s1_adv;
    assign w_tick     = w_accept && !r_halted && (i_in.action == kts_pkg::ACTION_TICK)
                        && (r_left != '0);
    assign w_hit      = kts_pkg::note_of_key(i_in.key_code);

    // table address from the top phase bits, mirrored in odd quadrants
    assign w_idx  = r_phase[PHASE_BITS-1 -: IDX_W];
    assign w_quad = w_idx[IDX_W-1 -: 2];
    assign w_pos  = {1'b0, w_idx[POS_W-1:0]};
    assign w_addr = w_quad[0] ? (ADDR_W'(SINE_TABLE_DEPTH) - w_pos) : w_pos;

    kts_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (w_s1_adv),
        .i_addr (w_addr),
        .o_data (w_mag)
    );

    always_comb begin
        n_phase  = r_phase;
        n_step   = r_step;
        n_octave = r_octave;
        n_left   = r_left;
        n_halted = r_halted;
        if (w_accept && !r_halted) begin
            if (i_in.action == kts_pkg::ACTION_KEY) begin
                case (i_in.key_code)
                    kts_pkg::KEY_QUIT_UPPER, kts_pkg::KEY_QUIT_LOWER: begin
                        n_halted = 1'b1;
                        n_left   = '0;
                    end
                    kts_pkg::KEY_OCT_DOWN: begin
                        if (r_octave != kts_pkg::OCT_MIN) begin
                            n_octave = r_octave - 1'b1;
                        end
                    end
                    kts_pkg::KEY_OCT_UP: begin
                        if (r_octave != kts_pkg::OCT_MAX) begin
                            n_octave = r_octave + 1'b1;
                        end
                    end
                    default: begin
                        if (w_hit.hit) begin
                            n_step  = w_step[w_hit.note][r_octave];
                            n_phase = '0;
                            n_left  = r_tone_length;
                        end
                    end
                endcase
            end else if (r_left != '0) begin
                n_left  = r_left - 1'b1;
                n_phase = r_phase + r_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= '0;
            r_step        <= '0;
            r_octave      <= kts_pkg::OCT_RESET;
            r_left        <= '0;
            r_halted      <= 1'b0;
            r_tone_length <= kts_pkg::LEN_RESET;
            r_amplitude   <= kts_pkg::AMP_RESET;
        end else begin
            r_phase  <= n_phase;
            r_step   <= n_step;
            r_octave <= n_octave;
            r_left   <= n_left;
            r_halted <= n_halted;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    kts_pkg::REG_TONE_LENGTH: r_tone_length <= i_cfg_data;
                    kts_pkg::REG_AMPLITUDE:   r_amplitude   <= i_cfg_data[kts_pkg::AMP_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // table read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_s1_valid <= w_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_s1_neg <= w_quad[1];
            r_s1_end <= (r_left == kts_pkg::LEN_W'(1));
        end
    end

    // amplitude scaling stage
    assign w_prod = PROD_W'(r_amplitude) * PROD_W'(w_mag);
    assign w_val  = kts_pkg::SAMPLE_W'(w_prod >> kts_pkg::Q30_SHIFT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_s1_valid) begin
            r_out_sample <= r_s1_neg ? $signed(kts_pkg::SAMPLE_W'(0) - w_val) : $signed(w_val);
            r_out_end    <= r_s1_end;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.sample   = r_out_sample;
    assign o_out.tone_end = r_out_end;

endmodule

### src/kts_checker.sv
// port-level assertions for the keyboard tone synthesizer and their bind
`timescale 1ns / 1ps

module kts_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic signed [kts_pkg::SAMPLE_W-1:0] i_out_sample,
    input logic                                i_out_tone_end
);

    // output register is empty right after reset
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output beat present after reset");

    // a stalled sample beat holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_sample) && $stable(i_out_tone_end))
        else $error("stalled sample beat changed");

    // a fresh sample follows a taken input beat through the table and output registers
    a_out_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("sample beat without a matching input beat");

    // the input side never blocks while the output register is empty
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input held off with an empty output register");

endmodule

bind keyboard_tone_synthesizer kts_checker u_kts_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_sample   (o_out.sample),
    .i_out_tone_end (o_out.tone_end)
);

### bench/kts_tone_checker.sv
// sample predictor and scoreboard for the keyboard tone synthesizer channels
`timescale 1ns / 1ps

module kts_tone_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    kts_in_if                              i_keys,
    kts_out_if                             i_samples,
    input  logic                           i_cfg_we,
    input  kts_pkg::t_cfg_idx              i_cfg_index,
    input  logic [kts_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);

    localparam int QUARTER = 1024;

    typedef struct packed {
        logic signed [kts_pkg::SAMPLE_W-1:0] sample;
        logic                                tone_end;
    } t_sample_beat;

    longint unsigned             sine_quarter [0:QUARTER];
    t_sample_beat                due_samples [$];
    logic [31:0]                 phase_acc;
    logic [31:0]                 phase_inc;
    logic [kts_pkg::OCT_W-1:0]   octave;
    logic [kts_pkg::LEN_W-1:0]   samples_left;
    logic                        halted;
    logic [kts_pkg::LEN_W-1:0]   tone_len;
    logic [kts_pkg::AMP_W-1:0]   amp;
    int                          fails = 0;

    initial begin : build_sine
        longint unsigned ang;
        longint unsigned sq;
        longint unsigned term;
        longint          acc;
        for (int k = 0; k <= QUARTER; k++) begin
            ang  = (kts_pkg::PI_HALF_Q30 * 64'(k)) / 64'(QUARTER);
            sq   = (ang * ang) >> 30;
            term = ang;
            acc  = longint'(ang);
            // taylor terms through x^17, signs alternate starting with minus
            for (int n = 1; n < 17; n += 2) begin
                term = ((term * sq) >> 30) / 64'((n + 1) * (n + 2));
                if (n % 4 == 1) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end else if (acc > longint'(kts_pkg::Q30_ONE)) begin
                acc = longint'(kts_pkg::Q30_ONE);
            end
            sine_quarter[k] = longint'(acc);
        end
    end

    always @(posedge i_clk) begin : predict_and_compare
        logic [11:0]     idx;
        logic [95:0]     quot;
        longint unsigned mag;
        longint unsigned val;
        int              note_idx;
        t_sample_beat    want;
        if (!i_rst_n) begin
            phase_acc    = '0;
            phase_inc    = '0;
            octave       = kts_pkg::OCT_RESET;
            samples_left = '0;
            halted       = 1'b0;
            tone_len     = kts_pkg::LEN_RESET;
            amp          = kts_pkg::AMP_RESET;
            due_samples.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == kts_pkg::REG_TONE_LENGTH) begin
                    tone_len = i_cfg_data[kts_pkg::LEN_W-1:0];
                end else if (i_cfg_index == kts_pkg::REG_AMPLITUDE) begin
                    amp = i_cfg_data[kts_pkg::AMP_W-1:0];
                end
            end

            if (i_keys.valid && i_keys.ready && !halted) begin
                if (i_keys.action == kts_pkg::ACTION_KEY) begin
                    if (i_keys.key_code == kts_pkg::KEY_QUIT_UPPER
                        || i_keys.key_code == kts_pkg::KEY_QUIT_LOWER) begin
                        halted       = 1'b1;
                        samples_left = '0;
                    end else if (i_keys.key_code == kts_pkg::KEY_OCT_DOWN) begin
                        if (octave > kts_pkg::OCT_MIN) octave = octave - 1'b1;
                    end else if (i_keys.key_code == kts_pkg::KEY_OCT_UP) begin
                        if (octave < kts_pkg::OCT_MAX) octave = octave + 1'b1;
                    end else begin
                        note_idx = -1;
                        for (int i = 0; i < kts_pkg::NOTE_COUNT; i++) begin
                            if (i_keys.key_code == kts_pkg::NOTE_KEYS[i]) note_idx = i;
                        end
                        if (note_idx >= 0) begin
                            // step = f * 2^(28 + octave) / fs, rounded half up
                            quot = (96'(kts_pkg::NOTE_MHZ[note_idx]) << (29 + int'(octave)))
                                   / 96'(1000 * kts_pkg::SAMPLE_RATE_HZ);
                            quot = (quot + 96'd1) >> 1;
                            phase_inc    = quot[31:0];
                            phase_acc    = '0;
                            samples_left = tone_len;
                        end
                    end
                end else if (samples_left != '0) begin
                    idx  = phase_acc[31:20];
                    mag  = idx[10] ? sine_quarter[QUARTER - int'(idx[9:0])]
                                   : sine_quarter[idx[9:0]];
                    val  = (64'(amp) * mag) >> 30;
                    want.sample   = kts_pkg::SAMPLE_W'(val);
                    if (idx[11]) want.sample = -want.sample;
                    want.tone_end = (samples_left == kts_pkg::LEN_W'(1));
                    due_samples.push_back(want);
                    samples_left = samples_left - 1'b1;
                    phase_acc    = phase_acc + phase_inc;
                end
            end

            if (i_samples.valid && i_samples.ready) begin
                if (due_samples.size() == 0) begin
                    $error("sample beat with none expected: sample %0d tone_end %0b",
                           i_samples.sample, i_samples.tone_end);
                    fails++;
                end else begin
                    want = due_samples.pop_front();
                    if (i_samples.sample !== want.sample) begin
                        $error("sample mismatch: expected %0d, got %0d",
                               want.sample, i_samples.sample);
                        fails++;
                    end
                    if (i_samples.tone_end !== want.tone_end) begin
                        $error("tone_end mismatch: expected %0b, got %0b",
                               want.tone_end, i_samples.tone_end);
                        fails++;
                    end
                end
            end
        end
        o_pending    <= due_samples.size();
        o_fail_count <= fails;
    end

endmodule

### bench/tb_keyboard_tone_synthesizer.sv
// stimulus, flow control and verdict for the keyboard tone synthesizer
`timescale 1ns / 1ps

module tb_keyboard_tone_synthesizer;

    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_BEATS = 250;
    localparam int LONG_HOLD   = 300;

    logic                           clk   = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we;
    kts_pkg::t_cfg_idx              cfg_index;
    logic [kts_pkg::CFG_DATA_W-1:0] cfg_data;
    int                             fail_count;
    int                             pending;
    int                             send_idle_pct  = 0;
    int                             recv_idle_pct  = 0;
    int                             hold_left      = 0;
    int                             quiet_cycles   = 0;
    logic                           long_hold_req  = 1'b0;
    logic                           long_hold_done = 1'b0;

    kts_in_if  key_ch ();
    kts_out_if smp_ch ();

    keyboard_tone_synthesizer DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (key_ch),
        .o_out       (smp_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    kts_tone_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_keys       (key_ch),
        .i_samples    (smp_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #1 clk = ~clk;

    // sample sink: random stalls, plus a long hold-off on request
    always @(posedge clk) begin
        if (long_hold_req && !long_hold_done) begin
            long_hold_done <= 1'b1;
            smp_ch.ready   <= 1'b0;
            hold_left      <= LONG_HOLD - 1;
        end else if (hold_left > 0) begin
            smp_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else begin
            smp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if ((key_ch.valid && key_ch.ready) || (smp_ch.valid && smp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_beat(input logic act, input logic [kts_pkg::KEY_W-1:0] key);
        while ($urandom_range(99) < send_idle_pct) begin
            key_ch.valid    <= 1'b0;
            key_ch.action   <= 1'($urandom);
            key_ch.key_code <= kts_pkg::KEY_W'($urandom);
            @(posedge clk);
        end
        key_ch.valid    <= 1'b1;
        key_ch.action   <= act;
        key_ch.key_code <= key;
        @(posedge clk);
        while (!key_ch.ready) @(posedge clk);
    endtask

    task automatic settle();
        key_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_tone(input logic [kts_pkg::CFG_DATA_W-1:0] len,
                            input logic [kts_pkg::CFG_DATA_W-1:0] level);
        cfg_we    <= 1'b1;
        cfg_index <= kts_pkg::REG_TONE_LENGTH;
        cfg_data  <= len;
        @(posedge clk);
        cfg_index <= kts_pkg::REG_AMPLITUDE;
        cfg_data  <= level;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin : stimulus
        logic [kts_pkg::KEY_W-1:0] key;
        int                        pick;
        logic                      upper_first;
        key_ch.valid    = 1'b0;
        key_ch.action   = kts_pkg::ACTION_KEY;
        key_ch.key_code = '0;
        cfg_we          = 1'b0;
        cfg_index       = kts_pkg::REG_TONE_LENGTH;
        cfg_data        = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: tick with no tone, unmapped keys mid-tone, octave limits
        send_beat(kts_pkg::ACTION_TICK, kts_pkg::KEY_QUIT_UPPER);
        send_beat(kts_pkg::ACTION_KEY, kts_pkg::NOTE_KEYS[0]);
        send_beat(kts_pkg::ACTION_TICK, 8'h00);
        send_beat(kts_pkg::ACTION_TICK, 8'hFF);
        send_beat(kts_pkg::ACTION_KEY, 8'h00);
        send_beat(kts_pkg::ACTION_TICK, kts_pkg::KEY_QUIT_LOWER);
        send_beat(kts_pkg::ACTION_KEY, 8'hFF);
        repeat (5) send_beat(kts_pkg::ACTION_KEY, kts_pkg::KEY_OCT_UP);
        send_beat(kts_pkg::ACTION_KEY, kts_pkg::NOTE_KEYS[11]);
        send_beat(kts_pkg::ACTION_TICK, 8'h55);
        repeat (9) send_beat(kts_pkg::ACTION_KEY, kts_pkg::KEY_OCT_DOWN);
        send_beat(kts_pkg::ACTION_KEY, kts_pkg::NOTE_KEYS[9]);
        send_beat(kts_pkg::ACTION_TICK, 8'hAA);
        settle();

        // one-sample tone at full level, then a zero-length tone
        set_tone(16'd1, 16'hFFFF);
        send_beat(kts_pkg::ACTION_KEY, kts_pkg::NOTE_KEYS[10]);
        send_beat(kts_pkg::ACTION_TICK, 8'h00);
        send_beat(kts_pkg::ACTION_TICK, 8'h00);
        settle();
        set_tone(16'd0, 16'd12345);
        send_beat(kts_pkg::ACTION_KEY, kts_pkg::NOTE_KEYS[8]);
        send_beat(kts_pkg::ACTION_TICK, 8'h00);
        settle();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 34;
                    recv_idle_pct = 86;
                    set_tone(kts_pkg::CFG_DATA_W'($urandom_range(24, 1)), 16'h7FFF);
                end
                1: begin
                    send_idle_pct = 86;
                    recv_idle_pct = 34;
                    set_tone(kts_pkg::CFG_DATA_W'($urandom_range(40, 2)), 16'h8000);
                end
                2: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    set_tone(kts_pkg::CFG_DATA_W'($urandom_range(64, 1)),
                             kts_pkg::CFG_DATA_W'($urandom));
                end
                default: begin
                    set_tone(16'hFFFF, kts_pkg::CFG_DATA_W'($urandom));
                end
            endcase
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if (ph == 2 && n == 20) long_hold_req <= 1'b1;
                if (ph == 3 && n == PHASE_BEATS / 2) settle();
                pick = $urandom_range(99);
                if (pick < 68) begin
                    send_beat(kts_pkg::ACTION_TICK, kts_pkg::KEY_W'($urandom));
                end else if (pick < 80) begin
                    send_beat(kts_pkg::ACTION_KEY,
                              kts_pkg::NOTE_KEYS[$urandom_range(kts_pkg::NOTE_COUNT - 1)]);
                end else if (pick < 85) begin
                    send_beat(kts_pkg::ACTION_KEY, kts_pkg::KEY_OCT_DOWN);
                end else if (pick < 90) begin
                    send_beat(kts_pkg::ACTION_KEY, kts_pkg::KEY_OCT_UP);
                end else begin
                    key = kts_pkg::KEY_W'($urandom);
                    if (key == kts_pkg::KEY_QUIT_UPPER || key == kts_pkg::KEY_QUIT_LOWER) begin
                        key = 8'h00;
                    end
                    send_beat(kts_pkg::ACTION_KEY, key);
                end
            end
            settle();
        end

        // quit during a tone, then everything is ignored
        upper_first = 1'($urandom);
        send_beat(kts_pkg::ACTION_KEY,
                  kts_pkg::NOTE_KEYS[$urandom_range(kts_pkg::NOTE_COUNT - 1)]);
        send_beat(kts_pkg::ACTION_TICK, kts_pkg::KEY_W'($urandom));
        send_beat(kts_pkg::ACTION_KEY,
                  upper_first ? kts_pkg::KEY_QUIT_UPPER : kts_pkg::KEY_QUIT_LOWER);
        repeat (3) send_beat(kts_pkg::ACTION_TICK, kts_pkg::KEY_W'($urandom));
        send_beat(kts_pkg::ACTION_KEY,
                  upper_first ? kts_pkg::KEY_QUIT_LOWER : kts_pkg::KEY_QUIT_UPPER);
        send_beat(kts_pkg::ACTION_KEY, kts_pkg::NOTE_KEYS[0]);
        send_beat(kts_pkg::ACTION_KEY, kts_pkg::KEY_OCT_UP);
        send_beat(kts_pkg::ACTION_TICK, kts_pkg::KEY_W'($urandom));
        settle();

        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
